### rtl/core/htpt_pkg.sv
// Shared types and constants for the hotness tier promotion table.
// Table entry layout, tier codes, register indexes and sequencer states.
// No dependencies.
package htpt_pkg;

	localparam int FUNCTION_SLOTS = 1024;
	localparam int ADDR_W         = (FUNCTION_SLOTS > 1) ? $clog2(FUNCTION_SLOTS) : 1;
	localparam int IDX_W          = 10;
	localparam int RANGE_W        = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;
	localparam int CALLS_W        = 32;
	localparam int TIME_W         = 48;
	localparam int RUN_W          = 32;
	localparam int CNT_W          = 11;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_W          = 32;

	localparam logic [CALLS_W-1:0] CALLS_MAX = '1;
	localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
	localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

	typedef enum logic [1:0] {
		TIER_INTERP   = 2'd0,
		TIER_BASELINE = 2'd1,
		TIER_OPT      = 2'd2
	} tier_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIERING  = 2'd0,
		REG_BASE_THR = 2'd1,
		REG_OPT_THR  = 2'd2,
		REG_MIN_AVG  = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_MULT,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic               seen;
		logic [CALLS_W-1:0] calls;
		logic [TIME_W-1:0]  time_sum;
		tier_t              level;
	} entry_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [ADDR_W-1:0] rd_addr;
	} ram_ctl_t;

endpackage

### rtl/core/htpt_table.sv
// Per-function entry store: one write port, one registered read port.
// Depends on htpt_pkg for the entry layout and address width.
module htpt_table (
	input  logic              clk,
	input  htpt_pkg::ram_ctl_t ctl,
	input  htpt_pkg::entry_t  wr_data,
	output htpt_pkg::entry_t  rd_data
);
	import htpt_pkg::*;

	entry_t mem_q [FUNCTION_SLOTS];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[ctl.wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[ctl.rd_addr];
	end

endmodule

### rtl/core/hotness_tier_promotion_table.sv
// Top level of the hotness tier promotion table: sequencer, shared multiplier,
// promotion decision, global counters and configuration registers.
// Depends on htpt_pkg and htpt_table.
//
//  channel  | handshake         | payload
//  ---------+-------------------+-------------------------------------------------
//  report   | start / busy      | function_index, run_time
//  result   | done (1 cycle)    | current_level, promoted, call_total, functions_seen,
//           |                   | baseline_population, optimizing_population,
//           |                   | promotion_total
//  config   | cfg_wr            | cfg_index, cfg_data
//
// A report runs through accept with table read, entry update, one 32x32
// multiply for the average-time test, then decide and write back; done is
// registered from the decide state. busy drops with done, so the next report may
// be accepted at the edge that ends the done beat.
// After reset a clearing sweep zeroes the table, one entry a cycle, through all
// FUNCTION_SLOTS (1024) entries with busy high; config writes are taken meanwhile.
// The receiver cannot stall: each result beat is shown for one cycle only.
module hotness_tier_promotion_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [htpt_pkg::IDX_W-1:0]      function_index,
	input  logic [htpt_pkg::RUN_W-1:0]      run_time,
	output logic                            done,
	output logic [1:0]                      current_level,
	output logic                            promoted,
	output logic [htpt_pkg::CALLS_W-1:0]    call_total,
	output logic [htpt_pkg::CNT_W-1:0]      functions_seen,
	output logic [htpt_pkg::CNT_W-1:0]      baseline_population,
	output logic [htpt_pkg::CNT_W-1:0]      optimizing_population,
	output logic [htpt_pkg::CALLS_W-1:0]    promotion_total,
	input  logic                            cfg_wr,
	input  logic [htpt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [htpt_pkg::CFG_W-1:0]      cfg_data
);
	import htpt_pkg::*;

	state_t state_q, state_nx;

	logic               tiering_q;
	logic [CFG_W-1:0]   base_thr_q;
	logic [CFG_W-1:0]   opt_thr_q;
	logic [CFG_W-1:0]   min_avg_q;

	logic [ADDR_W-1:0]  clr_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               in_range_q;
	logic [RUN_W-1:0]   run_q;

	entry_t             rd_entry;
	entry_t             wr_entry;
	ram_ctl_t           ram_ctl;

	logic [CALLS_W-1:0] calls_q;
	logic [TIME_W-1:0]  sum_q;
	logic               seen_q;
	tier_t              level_q;
	logic [63:0]        prod_q;

	logic [CNT_W-1:0]   seen_cnt_q;
	logic [CNT_W-1:0]   base_cnt_q;
	logic [CNT_W-1:0]   opt_cnt_q;
	logic [CALLS_W-1:0] promo_cnt_q;

	logic               accept;
	logic [TIME_W:0]    sum_wide;
	logic               promo_base;
	logic               promo_opt;
	tier_t              level_new;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == ADDR_W'(FUNCTION_SLOTS - 1)) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_nx = ST_LOAD;
			end
			ST_LOAD:   state_nx = ST_MULT;
			ST_MULT:   state_nx = ST_DECIDE;
			ST_DECIDE: state_nx = ST_IDLE;
			default:   state_nx = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tiering_q  <= 1'b1;
			base_thr_q <= CFG_W'(100);
			opt_thr_q  <= CFG_W'(10000);
			min_avg_q  <= CFG_W'(1000);
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_TIERING:  tiering_q  <= cfg_data[0];
				REG_BASE_THR: base_thr_q <= cfg_data;
				REG_OPT_THR:  opt_thr_q  <= cfg_data;
				REG_MIN_AVG:  min_avg_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// beat capture
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q     <= ADDR_W'(function_index);
			in_range_q <= RANGE_W'(function_index) < RANGE_W'(FUNCTION_SLOTS);
			run_q      <= run_time;
		end
	end

	// entry update
	assign sum_wide = (TIME_W + 1)'(rd_entry.time_sum) + (TIME_W + 1)'(run_q);

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			calls_q <= (rd_entry.calls == CALLS_MAX) ? CALLS_MAX : rd_entry.calls + 1'b1;
			sum_q   <= sum_wide[TIME_W] ? TIME_MAX : sum_wide[TIME_W-1:0];
			seen_q  <= rd_entry.seen;
			level_q <= rd_entry.level;
		end
	end

	// shared multiplier for the average-time test
	always_ff @(posedge clk) begin
		if (state_q == ST_MULT) begin
			prod_q <= 64'(min_avg_q) * 64'(calls_q);
		end
	end

	// promotion decision
	always_comb begin
		promo_base = 1'b0;
		promo_opt  = 1'b0;
		level_new  = level_q;
		if (tiering_q && in_range_q) begin
			unique case (level_q)
				TIER_INTERP: begin
					promo_base = (calls_q >= base_thr_q);
				end
				TIER_BASELINE: begin
					promo_opt = (calls_q >= opt_thr_q) && (calls_q != '0)
						&& (64'(sum_q) >= prod_q);
				end
				default: ;
			endcase
		end
		if (promo_base) level_new = TIER_BASELINE;
		if (promo_opt)  level_new = TIER_OPT;
	end

	always_comb begin
		wr_entry          = '0;
		ram_ctl.wr_en     = 1'b0;
		ram_ctl.wr_addr   = addr_q;
		ram_ctl.rd_addr   = ADDR_W'(function_index);
		if (state_q == ST_CLEAR) begin
			ram_ctl.wr_en   = 1'b1;
			ram_ctl.wr_addr = clr_q;
		end else if (state_q == ST_DECIDE && in_range_q) begin
			ram_ctl.wr_en     = 1'b1;
			wr_entry.seen     = 1'b1;
			wr_entry.calls    = calls_q;
			wr_entry.time_sum = sum_q;
			wr_entry.level    = level_new;
		end
	end

	htpt_table u_table (
		.clk     (clk),
		.ctl     (ram_ctl),
		.wr_data (wr_entry),
		.rd_data (rd_entry)
	);

	// global counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_cnt_q  <= '0;
			base_cnt_q  <= '0;
			opt_cnt_q   <= '0;
			promo_cnt_q <= '0;
		end else if (state_q == ST_DECIDE && in_range_q) begin
			if (!seen_q && seen_cnt_q != CNT_MAX) seen_cnt_q <= seen_cnt_q + 1'b1;
			if (promo_base && base_cnt_q != CNT_MAX) begin
				base_cnt_q <= base_cnt_q + 1'b1;
			end else if (promo_opt && base_cnt_q != '0) begin
				base_cnt_q <= base_cnt_q - 1'b1;
			end
			if (promo_opt && opt_cnt_q != CNT_MAX) opt_cnt_q <= opt_cnt_q + 1'b1;
			if ((promo_base || promo_opt) && promo_cnt_q != CALLS_MAX) begin
				promo_cnt_q <= promo_cnt_q + 1'b1;
			end
		end
	end

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (state_q == ST_DECIDE);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE) begin
			current_level <= in_range_q ? level_new : TIER_INTERP;
			promoted      <= promo_base || promo_opt;
			call_total    <= in_range_q ? calls_q : '0;
		end
	end

	assign functions_seen        = seen_cnt_q;
	assign baseline_population   = base_cnt_q;
	assign optimizing_population = opt_cnt_q;
	assign promotion_total       = promo_cnt_q;

endmodule

### verif/hotness_tier_promotion_table_test.sv
`timescale 1ns / 100ps
// Testbench for hotness_tier_promotion_table: queued report and register beats, a
// clocked driver and monitor, and a tier predictor that checks every result beat.
// Depends on htpt_pkg and the RTL of the block.
module hotness_tier_promotion_table_test;
	import htpt_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int QUIET_NEEDED = 3;
	localparam int HOT_SLOTS    = 6;

	typedef struct {
		bit               is_cfg;
		cfg_reg_t         cfg_sel;
		logic [CFG_W-1:0] value;
		logic [IDX_W-1:0] fidx;
		logic [RUN_W-1:0] rtime;
		int               idle_pct;
	} op_t;

	typedef struct {
		logic [1:0]         level;
		logic               promoted;
		logic [CALLS_W-1:0] calls;
		logic [CNT_W-1:0]   seen;
		logic [CNT_W-1:0]   base_pop;
		logic [CNT_W-1:0]   opt_pop;
		logic [CALLS_W-1:0] promos;
	} outcome_t;

	logic                 clk;
	logic                 arst_n         = 1'b0;
	logic                 start          = 1'b0;
	logic                 busy;
	logic [IDX_W-1:0]     function_index = '0;
	logic [RUN_W-1:0]     run_time       = '0;
	logic                 done;
	logic [1:0]           current_level;
	logic                 promoted;
	logic [CALLS_W-1:0]   call_total;
	logic [CNT_W-1:0]     functions_seen;
	logic [CNT_W-1:0]     baseline_population;
	logic [CNT_W-1:0]     optimizing_population;
	logic [CALLS_W-1:0]   promotion_total;
	logic                 cfg_wr         = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index      = '0;
	logic [CFG_W-1:0]     cfg_data       = '0;

	hotness_tier_promotion_table uut (.*);

	// predicted table and counters
	bit                 seen_tab  [FUNCTION_SLOTS];
	bit [CALLS_W-1:0]   calls_tab [FUNCTION_SLOTS];
	bit [TIME_W-1:0]    sum_tab   [FUNCTION_SLOTS];
	tier_t              level_tab [FUNCTION_SLOTS] = '{default: TIER_INTERP};
	bit [CNT_W-1:0]     seen_cnt  = '0;
	bit [CNT_W-1:0]     base_cnt  = '0;
	bit [CNT_W-1:0]     opt_cnt   = '0;
	bit [CALLS_W-1:0]   promo_cnt = '0;

	bit                 tiering_on = 1'b1;
	bit [CFG_W-1:0]     base_thr   = 32'd100;
	bit [CFG_W-1:0]     opt_thr    = 32'd10000;
	bit [CFG_W-1:0]     min_avg    = 32'd1000;

	op_t      pending_ops[$];
	outcome_t promotion_outcomes[$];

	int fail_count      = 0;
	int reports_checked = 0;
	int promotions_seen = 0;
	int cfg_writes      = 0;
	int cycle_count     = 0;
	int quiet_cycles    = 0;

	function automatic bit [CNT_W-1:0] bump11(bit [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic void apply_config(cfg_reg_t sel, logic [CFG_W-1:0] v);
		case (sel)
			REG_TIERING:  tiering_on = v[0];
			REG_BASE_THR: base_thr   = v;
			REG_OPT_THR:  opt_thr    = v;
			REG_MIN_AVG:  min_avg    = v;
			default: ;
		endcase
	endfunction

	function automatic outcome_t apply_report(logic [IDX_W-1:0] fidx, logic [RUN_W-1:0] rtime);
		outcome_t    o;
		int unsigned slot;
		logic [TIME_W:0] sum_wide;
		logic [63:0] need;
		slot       = fidx;
		o.level    = TIER_INTERP;
		o.promoted = 1'b0;
		o.calls    = '0;
		if (slot < FUNCTION_SLOTS) begin
			if (!seen_tab[slot]) begin
				seen_tab[slot] = 1'b1;
				seen_cnt = bump11(seen_cnt);
			end
			if (calls_tab[slot] != CALLS_MAX)
				calls_tab[slot] = calls_tab[slot] + 1'b1;
			sum_wide = {1'b0, sum_tab[slot]} + rtime;
			sum_tab[slot] = sum_wide[TIME_W] ? TIME_MAX : sum_wide[TIME_W-1:0];
			o.calls = calls_tab[slot];
			if (tiering_on) begin
				if (level_tab[slot] == TIER_INTERP) begin
					if (o.calls >= base_thr) begin
						level_tab[slot] = TIER_BASELINE;
						base_cnt = bump11(base_cnt);
						o.promoted = 1'b1;
					end
				end else if (level_tab[slot] == TIER_BASELINE) begin
					need = 64'(min_avg) * 64'(o.calls);
					if (o.calls >= opt_thr && o.calls != 0 && 64'(sum_tab[slot]) >= need) begin
						level_tab[slot] = TIER_OPT;
						opt_cnt = bump11(opt_cnt);
						if (base_cnt != 0)
							base_cnt = base_cnt - 1'b1;
						o.promoted = 1'b1;
					end
				end
			end
			if (o.promoted && promo_cnt != CALLS_MAX)
				promo_cnt = promo_cnt + 1'b1;
			o.level = level_tab[slot];
		end
		o.seen     = seen_cnt;
		o.base_pop = base_cnt;
		o.opt_pop  = opt_cnt;
		o.promos   = promo_cnt;
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		fail_count++;
		$display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
	endtask

	task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	function automatic void queue_config(cfg_reg_t sel, logic [CFG_W-1:0] v);
		op_t op;
		op.is_cfg   = 1'b1;
		op.cfg_sel  = sel;
		op.value    = v;
		op.fidx     = '0;
		op.rtime    = '0;
		op.idle_pct = 0;
		pending_ops = {pending_ops, op};
	endfunction

	function automatic void queue_report(logic [IDX_W-1:0] fidx, logic [RUN_W-1:0] rtime,
			int idle_pct);
		op_t op;
		op.is_cfg   = 1'b0;
		op.cfg_sel  = REG_TIERING;
		op.value    = '0;
		op.fidx     = fidx;
		op.rtime    = rtime;
		op.idle_pct = idle_pct;
		pending_ops = {pending_ops, op};
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// driver
	op_t              drv_op;
	logic             drv_hold;
	logic             nxt_start;
	logic             nxt_wr;
	logic [IDX_W-1:0] nxt_fidx;
	logic [RUN_W-1:0] nxt_rt;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start          <= 1'b0;
			function_index <= '0;
			run_time       <= '0;
			cfg_wr         <= 1'b0;
			cfg_index      <= REG_TIERING;
			cfg_data       <= '0;
			quiet_cycles   = 0;
		end else begin
			drv_hold = start && busy;
			if (start && !busy)
				promotion_outcomes = {promotion_outcomes,
					apply_report(function_index, run_time)};
			if (promotion_outcomes.size() == 0 && !busy && !start && !done && !cfg_wr)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			nxt_start = drv_hold;
			nxt_wr    = 1'b0;
			nxt_fidx  = drv_hold ? function_index : IDX_W'($urandom);
			nxt_rt    = drv_hold ? run_time : $urandom;
			if (!drv_hold && pending_ops.size() != 0) begin
				drv_op = pending_ops[0];
				if (drv_op.is_cfg) begin
					if (quiet_cycles >= QUIET_NEEDED) begin
						void'(pending_ops.pop_front());
						apply_config(drv_op.cfg_sel, drv_op.value);
						nxt_wr = 1'b1;
						cfg_index <= drv_op.cfg_sel;
						cfg_data  <= drv_op.value;
						cfg_writes++;
						quiet_cycles = 0;
					end
				end else if ($urandom_range(0, 99) >= drv_op.idle_pct) begin
					void'(pending_ops.pop_front());
					nxt_start = 1'b1;
					nxt_fidx  = drv_op.fidx;
					nxt_rt    = drv_op.rtime;
				end
			end
			start          <= nxt_start;
			function_index <= nxt_fidx;
			run_time       <= nxt_rt;
			cfg_wr         <= nxt_wr;
		end
	end

	// monitor
	outcome_t mon_exp;

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (promotion_outcomes.size() == 0) begin
				report_mismatch("result beat with no report pending", call_total, 0);
			end else begin
				mon_exp = promotion_outcomes.pop_front();
				check_field("current_level", current_level, mon_exp.level);
				check_field("promoted", promoted, mon_exp.promoted);
				check_field("call_total", call_total, mon_exp.calls);
				check_field("functions_seen", functions_seen, mon_exp.seen);
				check_field("baseline_population", baseline_population, mon_exp.base_pop);
				check_field("optimizing_population", optimizing_population, mon_exp.opt_pop);
				check_field("promotion_total", promotion_total, mon_exp.promos);
				reports_checked++;
				if (mon_exp.promoted)
					promotions_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Timed out after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	// stimulus and end of run
	logic [IDX_W-1:0] hot [HOT_SLOTS];
	logic [CFG_W-1:0] phase_avg;
	logic [RUN_W-1:0] rt;
	int               idle;
	int               drain;

	initial begin
		// defaults after reset, extremes of both fields
		queue_report(10'd0, 32'd0, 10);
		queue_report(10'd1023, 32'hFFFF_FFFF, 10);
		queue_report(10'd1023, 32'd0, 10);
		// zero thresholds: promote on first report, then straight to optimizing
		queue_config(REG_BASE_THR, 32'd0);
		queue_config(REG_OPT_THR, 32'd0);
		queue_config(REG_MIN_AVG, 32'd0);
		queue_report(10'd5, 32'd0, 10);
		queue_report(10'd5, 32'd0, 10);
		queue_report(10'd5, 32'd123, 10);
		// average test exactly at and just under the largest threshold
		queue_config(REG_BASE_THR, 32'd1);
		queue_config(REG_OPT_THR, 32'd2);
		queue_config(REG_MIN_AVG, 32'hFFFF_FFFF);
		queue_report(10'd7, 32'hFFFF_FFFF, 10);
		queue_report(10'd7, 32'hFFFF_FFFF, 10);
		queue_report(10'd8, 32'hFFFF_FFFF, 10);
		queue_report(10'd8, 32'hFFFF_FFFE, 10);
		queue_report(10'd8, 32'hFFFF_FFFF, 10);
		// tiering off, upper data bits ignored
		queue_config(REG_TIERING, 32'hFFFF_FFFE);
		queue_report(10'd9, 32'd500, 10);
		queue_report(10'd8, 32'hFFFF_FFFF, 10);
		queue_config(REG_TIERING, 32'h0000_0001);
		queue_config(REG_BASE_THR, 32'hFFFF_FFFF);
		queue_report(10'd9, 32'd1, 10);
		queue_report(10'd8, 32'd0, 10);
		queue_config(REG_MIN_AVG, 32'd1000);
		queue_report(10'd8, 32'd0, 10);
		queue_report(10'd1, 32'd2000, 10);
		queue_report(10'd512, 32'h8000_0000, 10);
		queue_report(10'h155, 32'h5555_5555, 10);
		queue_report(10'h2AA, 32'hAAAA_AAAA, 10);

		for (int i = 0; i < HOT_SLOTS; i++)
			hot[i] = IDX_W'($urandom);
		for (int p = 0; p < 4; p++) begin
			// half of the hot set carries over so counts build across settings
			for (int i = 0; i < HOT_SLOTS / 2; i++)
				hot[i] = IDX_W'($urandom);
			case (p)
				0: begin
					idle = 10;
					phase_avg = $urandom_range(0, 1500);
					queue_config(REG_TIERING, $urandom | 32'd1);
					queue_config(REG_BASE_THR, $urandom_range(0, 4));
					queue_config(REG_OPT_THR, $urandom_range(0, 10));
				end
				1: begin
					idle = 78;
					phase_avg = 32'hFFFF_FFFF;
					queue_config(REG_BASE_THR, $urandom_range(0, 2));
					queue_config(REG_OPT_THR, $urandom_range(1, 6));
				end
				2: begin
					idle = 0;
					phase_avg = 32'd0;
					queue_config(REG_TIERING, $urandom & ~32'd1);
					queue_config(REG_BASE_THR, 32'd0);
					queue_config(REG_OPT_THR, 32'd0);
				end
				default: begin
					idle = 0;
					phase_avg = $urandom_range(0, 3000);
					queue_config(REG_TIERING, $urandom | 32'd1);
					queue_config(REG_BASE_THR, $urandom_range(0, 8));
					queue_config(REG_OPT_THR, $urandom_range(0, 15));
				end
			endcase
			queue_config(REG_MIN_AVG, phase_avg);
			for (int n = 0; n < 100; n++) begin
				if ($urandom_range(0, 3) != 0) begin
					if (phase_avg > 100000)
						rt = ($urandom_range(0, 2) != 0) ? 32'hFFFF_FFFF : $urandom;
					else
						rt = $urandom_range(0, 2 * phase_avg + 10);
					queue_report(hot[$urandom_range(0, HOT_SLOTS - 1)], rt, idle);
				end else begin
					queue_report(IDX_W'($urandom), $urandom, idle);
				end
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || start)
			@(negedge clk);
		drain = 0;
		while (promotion_outcomes.size() != 0 && drain < 1000) begin
			@(negedge clk);
			drain++;
		end
		repeat (12) @(negedge clk);
		if (promotion_outcomes.size() != 0)
			report_mismatch("results never delivered", 0, promotion_outcomes.size());
		$display("Checked %0d report results, %0d promotions, %0d register writes",
			reports_checked, promotions_seen, cfg_writes);
		$display("covering zero and full-scale thresholds, tiering off and sender idle gaps");
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
